// File: rtl/core/bbfi_pkg.sv
// Shared types and constants for the blocked Bloom filter insert core.
package bbfi_pkg;

   // Width of the probe count register and of the result count
   localparam int unsigned CNT_W = 5;
   localparam logic [CNT_W-1:0] PROBE_RESET = 5'd4;

   // Filter words are 64 bits wide; low 6 bits of a bit index pick the bit
   localparam int unsigned WORD_W     = 64;
   localparam int unsigned WORD_SHIFT = 6;

   // Stride gets bumped when its low five bits are all zero
   localparam int unsigned STRIDE_LOW_W = 5;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_PROBE = 3'b100
   } back_state_type;

   // Result beat from the back end
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } rsp_type;

endpackage

// File: rtl/core/bbfi_front.sv
// Front end: takes request beats, splits the hash into block, start and stride.
module bbfi_front #(
   parameter int unsigned FILTER_SHIFT = 20,
   parameter int unsigned BLOCK_SHIFT  = 9,
   parameter int unsigned SEL_W        = 11,
   parameter int unsigned BLK_W        = 11,
   parameter int unsigned ITEM_W       = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [63:0]       hash_value_i,
   input  logic              clearing_i,
   input  logic              q_full_i,
   output logic              busy_o,
   output logic              q_push_o,
   output logic [ITEM_W-1:0] q_item_o
);

   logic              front_valid_ff, front_valid_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic              accept;
   logic [63:0]       blk_mask;
   logic [BLK_W-1:0]       blk;
   logic [BLOCK_SHIFT-1:0] pos;
   logic [BLOCK_SHIFT-1:0] stride_raw;
   logic [BLOCK_SHIFT-1:0] stride;

   // Handshake: stage holds one decoded beat until the queue takes it
   assign busy_o   = clearing_i | (front_valid_ff & q_full_i);
   assign accept   = start & ~busy_o;
   assign q_push_o = front_valid_ff & ~q_full_i;
   assign q_item_o = item_ff;

   // Field split of the hash
   assign blk_mask   = (64'd1 << SEL_W) - 64'd1;
   assign blk        = BLK_W'(hash_value_i & blk_mask);
   assign pos        = BLOCK_SHIFT'(hash_value_i >> SEL_W);
   assign stride_raw = BLOCK_SHIFT'(hash_value_i >> FILTER_SHIFT);

   // Stride with all-zero low bits is bumped by one
   always_comb begin
      if (stride_raw[bbfi_pkg::STRIDE_LOW_W-1:0] == '0) begin
         stride = stride_raw + BLOCK_SHIFT'(1);
      end else begin
         stride = stride_raw;
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      item_in        = item_ff;
      if (accept) begin
         front_valid_in = 1'b1;
         item_in        = {blk, pos, stride};
      end else if (q_push_o) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// File: rtl/core/bbfi_queue.sv
// Two-entry queue of decoded items between front and back ends.
module bbfi_queue #(
   parameter int unsigned ITEM_W = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  logic [ITEM_W-1:0] push_item_i,
   input  logic              pop_i,
   output logic              full_o,
   output logic              valid_o,
   output logic [ITEM_W-1:0] pop_item_o
);

   logic [ITEM_W-1:0]               ent_ff [bbfi_pkg::QUEUE_DEPTH];
   logic [bbfi_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bbfi_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bbfi_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign full_o     = (cnt_ff == bbfi_pkg::QCNT_W'(bbfi_pkg::QUEUE_DEPTH));
   assign valid_o    = (cnt_ff != '0);
   assign pop_item_o = ent_ff[rd_ptr_ff];
   assign do_push    = push_i & ~full_o;
   assign do_pop     = pop_i & valid_o;

   // Pointer and fill count update
   always_comb begin
      rd_ptr_in = do_pop  ? rd_ptr_ff + bbfi_pkg::QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + bbfi_pkg::QPTR_W'(1) : wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + bbfi_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - bbfi_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_item_i;
      end
   end

endmodule

// File: rtl/core/bbfi_back.sv
// Back end: filter memory, clearing pass and the probe read-modify-write pipe.
module bbfi_back #(
   parameter int unsigned FILTER_SHIFT = 20,
   parameter int unsigned BLOCK_SHIFT  = 9,
   parameter int unsigned BLK_W        = 11,
   parameter int unsigned ITEM_W       = 29
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bbfi_pkg::CNT_W-1:0]   probe_count_i,
   input  logic                         q_valid_i,
   input  logic [ITEM_W-1:0]            q_item_i,
   output logic                         q_pop_o,
   output logic                         clearing_o,
   output bbfi_pkg::rsp_type            rsp_o
);

   localparam int unsigned ADDR_W = FILTER_SHIFT - bbfi_pkg::WORD_SHIFT;
   localparam int unsigned DEPTH  = 2 ** ADDR_W;
   localparam int unsigned BIT_W  = bbfi_pkg::WORD_SHIFT;
   localparam int unsigned W      = bbfi_pkg::WORD_W;
   localparam int unsigned CW     = bbfi_pkg::CNT_W;

   logic [W-1:0]  filter_mem_ff [DEPTH];
   logic [W-1:0]  rd_data_ff;

   bbfi_pkg::back_state_type state_ff, state_in;
   logic [ADDR_W-1:0]       clear_addr_ff, clear_addr_in;

   // Issue side
   logic [BLK_W-1:0]        blk_ff, blk_in;
   logic [BLOCK_SHIFT-1:0]  pos_ff, pos_in;
   logic [BLOCK_SHIFT-1:0]  stride_ff, stride_in;
   logic [CW-1:0]           left_ff, left_in;

   // Test-and-set stage
   logic                    t_valid_ff, t_valid_in;
   logic                    t_last_ff, t_last_in;
   logic [ADDR_W-1:0]       t_addr_ff;
   logic [BIT_W-1:0]        t_bit_ff;

   // Bypass of the word written last cycle
   logic                    byp_valid_ff;
   logic [ADDR_W-1:0]       byp_addr_ff;
   logic [W-1:0]            byp_data_ff;

   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;

   logic [FILTER_SHIFT-1:0] gbit;
   logic [ADDR_W-1:0]       rd_addr;
   logic [W-1:0]            word_cur;
   logic [W-1:0]            word_new;
   logic                    hit;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [W-1:0]            mem_wdata;

   assign clearing_o = (state_ff == bbfi_pkg::ST_CLEAR);
   assign q_pop_o    = (state_ff == bbfi_pkg::ST_IDLE) & q_valid_i & ~t_valid_ff;
   assign rsp_o      = '{valid: rsp_valid_ff, count: rsp_count_ff};

   // Word address of the probe being issued
   assign gbit    = (FILTER_SHIFT'(blk_ff) << BLOCK_SHIFT) | FILTER_SHIFT'(pos_ff);
   assign rd_addr = gbit[FILTER_SHIFT-1:BIT_W];

   // Test and set; forward the previous write on a same-word hit
   assign word_cur = (byp_valid_ff && (byp_addr_ff == t_addr_ff)) ? byp_data_ff : rd_data_ff;
   assign hit      = word_cur[t_bit_ff];
   assign word_new = word_cur | (W'(1) << t_bit_ff);

   // Single write port shared by the clearing pass and the probes
   assign mem_we    = clearing_o | t_valid_ff;
   assign mem_waddr = clearing_o ? clear_addr_ff : t_addr_ff;
   assign mem_wdata = clearing_o ? '0 : word_new;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      blk_in        = blk_ff;
      pos_in        = pos_ff;
      stride_in     = stride_ff;
      left_in       = left_ff;
      t_valid_in    = 1'b0;
      t_last_in     = 1'b0;
      case (state_ff)
         bbfi_pkg::ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == '1) begin
               state_in = bbfi_pkg::ST_IDLE;
            end
         end
         bbfi_pkg::ST_IDLE: begin
            if (q_pop_o) begin
               blk_in    = q_item_i[ITEM_W-1 -: BLK_W];
               pos_in    = q_item_i[2*BLOCK_SHIFT-1 -: BLOCK_SHIFT];
               stride_in = q_item_i[BLOCK_SHIFT-1:0];
               left_in   = probe_count_i;
               if (probe_count_i != '0) begin
                  state_in = bbfi_pkg::ST_PROBE;
               end
            end
         end
         bbfi_pkg::ST_PROBE: begin
            t_valid_in = 1'b1;
            t_last_in  = (left_ff == CW'(1));
            pos_in     = pos_ff + stride_ff;
            left_in    = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = bbfi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bbfi_pkg::ST_IDLE;
         end
      endcase
   end

   // Hit count and result beat
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      if (q_pop_o) begin
         count_in = '0;
         if (probe_count_i == '0) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = '0;
         end
      end else if (t_valid_ff) begin
         if (t_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = count_ff + CW'(hit);
         end else begin
            count_in = count_ff + CW'(hit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bbfi_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         t_valid_ff    <= 1'b0;
         byp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         t_valid_ff    <= t_valid_in;
         byp_valid_ff  <= t_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      pos_ff       <= pos_in;
      stride_ff    <= stride_in;
      left_ff      <= left_in;
      t_last_ff    <= t_last_in;
      t_addr_ff    <= rd_addr;
      t_bit_ff     <= pos_ff[BIT_W-1:0];
      byp_addr_ff  <= t_addr_ff;
      byp_data_ff  <= word_new;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Filter memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         filter_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= filter_mem_ff[rd_addr];
   end

`ifndef SYNTHESIS
   a_no_probe_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbfi_pkg::ST_CLEAR) |-> !t_valid_ff)
      else $error("probe in test stage during clearing pass");

   a_probe_feeds_test: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbfi_pkg::ST_PROBE) |=> t_valid_ff)
      else $error("issued probe did not reach test stage");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (t_valid_ff && t_last_ff) |=> rsp_valid_ff)
      else $error("last probe did not produce a result beat");

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      q_pop_o |=> ((state_ff == bbfi_pkg::ST_PROBE) || rsp_valid_ff))
      else $error("popped item neither probed nor answered");
`endif

endmodule

// File: rtl/core/blocked_bloom_filter_insert_core.sv
// Top level of the blocked Bloom filter insert core.
//
// Each request beat carries a 64-bit hash; one result beat per request returns
// how many of the probed bits were already set. After reset the filter memory
// is swept to zero one 64-bit word per cycle, 2^(FILTER_SHIFT-6) words
// (16384 at the defaults), with busy high throughout. In the back end an item
// is loaded, then probed at one probe per cycle through the single read and
// single write port of the filter memory, and its last test and set finishes
// before the next item is loaded. A zero probe count answers 0 in the cycle
// after its item is loaded. A front register and a two-entry queue take new
// requests while the back end works; busy rises when both are full. Results
// show on rsp_valid for exactly one cycle and cannot be held off.
// FILTER_SHIFT must exceed BLOCK_SHIFT.
module blocked_bloom_filter_insert_core #(
   parameter int unsigned FILTER_SHIFT = 20,
   parameter int unsigned BLOCK_SHIFT  = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [63:0]                req_hash_value,
   output logic                       rsp_valid,
   output logic [bbfi_pkg::CNT_W-1:0] rsp_already_set_count,
   input  logic                       csr_write_enable,
   input  logic [bbfi_pkg::CNT_W-1:0] csr_write_data
);

   localparam int unsigned SEL_W  = FILTER_SHIFT - BLOCK_SHIFT;
   localparam int unsigned BLK_W  = (SEL_W > 0) ? SEL_W : 1;
   localparam int unsigned ITEM_W = BLK_W + 2 * BLOCK_SHIFT;

   logic [bbfi_pkg::CNT_W-1:0] probe_count_ff, probe_count_in;
   logic                       clearing;
   logic                       q_full, q_push, q_pop, q_valid;
   logic [ITEM_W-1:0]          push_item, pop_item;
   bbfi_pkg::rsp_type          rsp;

   // Probe count register
   assign probe_count_in = csr_write_enable ? csr_write_data : probe_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_count_ff <= bbfi_pkg::PROBE_RESET;
      end else begin
         probe_count_ff <= probe_count_in;
      end
   end

   bbfi_front #(
      .FILTER_SHIFT (FILTER_SHIFT),
      .BLOCK_SHIFT  (BLOCK_SHIFT),
      .SEL_W        (SEL_W),
      .BLK_W        (BLK_W),
      .ITEM_W       (ITEM_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .hash_value_i (req_hash_value),
      .clearing_i   (clearing),
      .q_full_i     (q_full),
      .busy_o       (busy),
      .q_push_o     (q_push),
      .q_item_o     (push_item)
   );

   bbfi_queue #(
      .ITEM_W (ITEM_W)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (q_push),
      .push_item_i (push_item),
      .pop_i       (q_pop),
      .full_o      (q_full),
      .valid_o     (q_valid),
      .pop_item_o  (pop_item)
   );

   bbfi_back #(
      .FILTER_SHIFT (FILTER_SHIFT),
      .BLOCK_SHIFT  (BLOCK_SHIFT),
      .BLK_W        (BLK_W),
      .ITEM_W       (ITEM_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .probe_count_i (probe_count_ff),
      .q_valid_i     (q_valid),
      .q_item_i      (pop_item),
      .q_pop_o       (q_pop),
      .clearing_o    (clearing),
      .rsp_o         (rsp)
   );

   // Result beat
   assign rsp_valid             = rsp.valid;
   assign rsp_already_set_count = rsp.count;

endmodule

// File: dv/blocked_bloom_filter_insert_core_checker.sv
// Scoreboard for the blocked Bloom filter insert core: shadow filter, predictor and compare.
module blocked_bloom_filter_insert_core_checker #(
   parameter int unsigned FILTER_SHIFT = 20,
   parameter int unsigned BLOCK_SHIFT  = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [63:0]                req_hash_value,
   input  logic                       rsp_valid,
   input  logic [bbfi_pkg::CNT_W-1:0] rsp_already_set_count,
   input  logic                       csr_write_enable,
   input  logic [bbfi_pkg::CNT_W-1:0] csr_write_data,
   output int unsigned                fail_count,
   output int unsigned                pending_count
);

   localparam int unsigned SEL_W      = FILTER_SHIFT - BLOCK_SHIFT;
   localparam int unsigned WORD_COUNT = 1 << (FILTER_SHIFT - bbfi_pkg::WORD_SHIFT);
   localparam logic [63:0] SEL_MASK   = (64'd1 << SEL_W) - 64'd1;
   localparam logic [63:0] BLOCK_MASK = (64'd1 << BLOCK_SHIFT) - 64'd1;
   localparam int unsigned LOW_MASK   = (1 << bbfi_pkg::STRIDE_LOW_W) - 1;

   // Shadow copy of the filter memory and the probe count register
   logic [bbfi_pkg::WORD_W-1:0] shadow_words [WORD_COUNT];
   logic [bbfi_pkg::CNT_W-1:0]  probe_setting;
   logic [bbfi_pkg::CNT_W-1:0]  expected_hit_counts [$];
   int unsigned                 mismatch_total = 0;

   // Walk the probe sequence of one hash, count bits already set, then set them
   function automatic logic [bbfi_pkg::CNT_W-1:0] insert_and_count_hits(logic [63:0] hash);
      int unsigned                block_sel;
      int unsigned                bit_pos;
      int unsigned                stride;
      int unsigned                global_bit;
      logic [bbfi_pkg::CNT_W-1:0] hits;
      block_sel = 32'(hash & SEL_MASK);
      bit_pos   = 32'((hash >> SEL_W) & BLOCK_MASK);
      stride    = 32'((hash >> FILTER_SHIFT) & BLOCK_MASK);
      hits      = '0;
      // stride with no low bits set is nudged up by one, wrapping in the block
      if ((stride & LOW_MASK) == 0)
         stride = 32'((64'(stride) + 64'd1) & BLOCK_MASK);
      for (int unsigned probe = 0; probe < probe_setting; probe++) begin
         global_bit = (block_sel << BLOCK_SHIFT) + bit_pos;
         if (shadow_words[global_bit >> bbfi_pkg::WORD_SHIFT][global_bit % bbfi_pkg::WORD_W])
            hits++;
         shadow_words[global_bit >> bbfi_pkg::WORD_SHIFT][global_bit % bbfi_pkg::WORD_W] = 1'b1;
         bit_pos = 32'((64'(bit_pos) + 64'(stride)) & BLOCK_MASK);
      end
      return hits;
   endfunction

   // Compare result beats, track config writes, predict on accepted request beats
   always @(posedge clock) begin
      logic [bbfi_pkg::CNT_W-1:0] want;
      if (reset) begin
         foreach (shadow_words[w])
            shadow_words[w] = '0;
         probe_setting = bbfi_pkg::PROBE_RESET;
         expected_hit_counts.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_hit_counts.size() == 0) begin
               $error("unexpected result beat: already_set_count actual %0d",
                      rsp_already_set_count);
               mismatch_total++;
            end else begin
               want = expected_hit_counts.pop_front();
               if (rsp_already_set_count !== want) begin
                  $error("already_set_count mismatch: expected %0d, actual %0d",
                         want, rsp_already_set_count);
                  mismatch_total++;
               end
            end
         end
         if (csr_write_enable)
            probe_setting = csr_write_data;
         if (start && !busy)
            expected_hit_counts.push_back(insert_and_count_hits(req_hash_value));
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_hit_counts.size();
   end

endmodule

// File: dv/blocked_bloom_filter_insert_core_tb.sv
// Top of the blocked Bloom filter insert core testbench: clock, reset, stimulus and verdict.
module blocked_bloom_filter_insert_core_tb;

   localparam int unsigned FILTER_SHIFT  = 20;
   localparam int unsigned BLOCK_SHIFT   = 9;
   localparam int unsigned SEL_W         = FILTER_SHIFT - BLOCK_SHIFT;
   localparam int unsigned LAST_BLOCK    = (1 << SEL_W) - 1;
   localparam int unsigned LAST_POS      = (1 << BLOCK_SHIFT) - 1;
   localparam int unsigned MAX_GAP       = 12;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned IDLE_LIMIT    = 50000;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_ITEMS   = 124;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       start            = 1'b0;
   logic                       busy;
   logic [63:0]                req_hash_value   = '0;
   logic                       rsp_valid;
   logic [bbfi_pkg::CNT_W-1:0] rsp_already_set_count;
   logic                       csr_write_enable = 1'b0;
   logic [bbfi_pkg::CNT_W-1:0] csr_write_data   = '0;
   int unsigned                fail_count;
   int unsigned                pending_hits;
   int unsigned                idle_cycles      = 0;
   bit                         calm             = 1'b0;
   logic [63:0]                recent_hashes [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   blocked_bloom_filter_insert_core #(
      .FILTER_SHIFT(FILTER_SHIFT),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_hash_value       (req_hash_value),
      .rsp_valid            (rsp_valid),
      .rsp_already_set_count(rsp_already_set_count),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   blocked_bloom_filter_insert_core_checker #(
      .FILTER_SHIFT(FILTER_SHIFT),
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_hash_value       (req_hash_value),
      .rsp_valid            (rsp_valid),
      .rsp_already_set_count(rsp_already_set_count),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .fail_count           (fail_count),
      .pending_count        (pending_hits)
   );

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("blocked_bloom_filter_insert_core regression: fail");
         $finish;
      end
   end

   // Pack block select, start position, stride and the ignored upper bits
   function automatic logic [63:0] compose_hash(int unsigned block_sel, int unsigned first_pos,
                                               int unsigned stride, logic [63:0] upper);
      return (upper << (FILTER_SHIFT + BLOCK_SHIFT))
           | (64'(stride & LAST_POS) << FILTER_SHIFT)
           | (64'(first_pos & LAST_POS) << SEL_W)
           | 64'(block_sel & LAST_BLOCK);
   endfunction

   // Mostly hashes aimed at a few hot blocks so bits pile up; some repeats, some noise
   function automatic logic [63:0] pick_hash();
      int unsigned roll;
      int unsigned block_sel;
      int unsigned stride;
      roll = $urandom_range(0, 99);
      if (roll < 10 && recent_hashes.size() != 0)
         return recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
      if (roll < 80) begin
         block_sel = $urandom_range(0, 15);
         if ($urandom_range(0, 1))
            block_sel = LAST_BLOCK - block_sel;
         stride = $urandom_range(0, LAST_POS);
         // strides with empty low bits get the bump path
         if ($urandom_range(0, 4) == 0)
            stride = $urandom_range(0, 15) << bbfi_pkg::STRIDE_LOW_W;
         return compose_hash(block_sel, $urandom_range(0, LAST_POS), stride,
                             {$urandom, $urandom});
      end
      return {$urandom, $urandom};
   endfunction

   // One request beat, after a random gap unless running back to back
   task automatic send_hash(logic [63:0] hash);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_hash_value <= hash;
      do @(posedge clock); while (busy);
      recent_hashes.push_back(hash);
      if (recent_hashes.size() > 16)
         void'(recent_hashes.pop_front());
   endtask

   // Hold off until every predicted result beat has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_hits != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_probe_count(logic [bbfi_pkg::CNT_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [bbfi_pkg::CNT_W-1:0] probe_plan [RANDOM_PHASES];
      probe_plan = '{5'd1, 5'd31, 5'd4, 5'd16, 5'd2, 5'd0, 5'd8, 5'd31, 5'd3, 5'd4};
      probe_plan[RANDOM_PHASES-1] = bbfi_pkg::CNT_W'($urandom_range(0, 31));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset probe count, field extremes, repeats, stride bump
      send_hash(64'd0);
      send_hash(64'd0);
      send_hash('1);
      // unused upper bits differ, same probe positions as all ones
      send_hash(compose_hash(LAST_BLOCK, LAST_POS, LAST_POS, 64'd0));
      send_hash(compose_hash(5, 0, 256, 64'd0));
      send_hash(compose_hash(5, 0, 32, 64'd0));
      send_hash(compose_hash(6, 100, 16, 64'd0));
      send_hash(compose_hash(1024, LAST_POS, 1, {$urandom, $urandom}));

      // Largest probe count, narrow stride, same positions again
      write_probe_count(5'd31);
      send_hash(compose_hash(7, 3, 16, 64'd0));
      send_hash(compose_hash(7, 3, 16, 64'd0));
      send_hash(compose_hash(7, 3, 16, '1));

      // Zero probes: nothing visited, count is zero
      write_probe_count(5'd0);
      send_hash(64'd0);
      send_hash('1);

      write_probe_count(5'd16);
      send_hash(compose_hash(8, 0, 0, 64'd0));
      send_hash(compose_hash(8, 0, 0, 64'd0));
      send_hash(compose_hash(LAST_BLOCK, 0, LAST_POS, '1));

      // Random phases, one probe count each
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_probe_count(probe_plan[phase]);
         calm = ($urandom_range(0, 3) == 0);
         for (int unsigned item = 0; item < PHASE_ITEMS; item++) begin
            if (phase == 3 && item == PHASE_ITEMS / 2)
               drain_results();
            if ($urandom_range(0, 31) == 0)
               calm = !calm;
            send_hash(pick_hash());
         end
      end

      drain_results();
      if (fail_count == 0)
         $display("blocked_bloom_filter_insert_core regression: pass");
      else
         $display("blocked_bloom_filter_insert_core regression: fail");
      $finish;
   end

endmodule

// File: blocked_bloom_filter_insert_core.f
rtl/core/bbfi_pkg.sv
rtl/core/bbfi_front.sv
rtl/core/bbfi_queue.sv
rtl/core/bbfi_back.sv
rtl/core/blocked_bloom_filter_insert_core.sv
dv/blocked_bloom_filter_insert_core_checker.sv
dv/blocked_bloom_filter_insert_core_tb.sv
